@@ rtl/core/xor_distance_node_table_macros.svh @@
// Assertion helpers shared by the node table RTL
`ifndef XOR_DISTANCE_NODE_TABLE_MACROS_SVH
`define XOR_DISTANCE_NODE_TABLE_MACROS_SVH

// expression holds at every clock edge out of reset
`define XDNT_ASSERT_HOLDS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define XDNT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/xdnt_pkg.sv @@
package xdnt_pkg;

   localparam int unsigned DEF_TABLE_DEPTH = 256;
   localparam int unsigned DEF_PER_REQUEST = 3;
   localparam int unsigned ID_W   = 160;
   localparam int unsigned ADDR_W = 32;
   localparam int unsigned PORT_W = 16;
   localparam int unsigned CSR_W  = 64;

   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_RESPOND = 2'd1,
      OP_NEXT    = 2'd2,
      OP_SORT    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_ADDED      = 3'd0,
      ST_DUPLICATE  = 3'd1,
      ST_FULL       = 3'd2,
      ST_PORT_ZERO  = 3'd3,
      ST_FOUND      = 3'd4,
      ST_NOT_FOUND  = 3'd5,
      ST_GIVEN      = 3'd6,
      ST_DONE       = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      CSR_TARGET_HIGH   = 2'd0,
      CSR_TARGET_MIDDLE = 2'd1,
      CSR_TARGET_LOW    = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FIND_RD,
      S_FIND_CK,
      S_NX_RD,
      S_NX_CK,
      S_SO_NEXT,
      S_SO_KRD,
      S_SO_KCK,
      S_SO_CMP,
      S_SO_PLACE,
      S_SO_DONE
   } fsm_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [ADDR_W-1:0] address;
      logic [PORT_W-1:0] port;
      logic              queried;
      logic              responded;
   } entry_type;

   typedef struct packed {
      status_type        status;
      logic [ADDR_W-1:0] address;
      logic [PORT_W-1:0] port;
      logic [ID_W-1:0]   id;
      logic              last;
   } result_type;

   // a strictly closer to target than b
   function automatic logic nearer(logic [ID_W-1:0] a, logic [ID_W-1:0] b,
                                   logic [ID_W-1:0] target);
      return (a ^ target) < (b ^ target);
   endfunction

endpackage

@@ rtl/core/xor_distance_node_table.sv @@
// Node table of up to TABLE_DEPTH peers kept in one synchronous RAM, one
// request at a time. Insert and respond scan for a matching address and port,
// reading each entry examined and then comparing it; an insert with port zero
// is refused without a scan. Next scans for entries not yet queried, up to
// PER_REQUEST handouts; sort is an in-place insertion sort on the RAM, each
// key moved down one position at a time.
// A result waits in an output register; req_ready is high whenever no
// request is in progress. No clearing pass: entries at or past the count
// are never used.
`include "xor_distance_node_table_macros.svh"

module xor_distance_node_table #(
   parameter int unsigned TABLE_DEPTH = xdnt_pkg::DEF_TABLE_DEPTH,
   parameter int unsigned PER_REQUEST = xdnt_pkg::DEF_PER_REQUEST
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [63:0] req_in_id_high,
   input  logic [63:0] req_in_id_middle,
   input  logic [31:0] req_in_id_low,
   input  logic [31:0] req_in_address,
   input  logic [15:0] req_in_port,
   input  logic        req_id_present,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_out_address,
   output logic [15:0] rsp_out_port,
   output logic [63:0] rsp_out_id_high,
   output logic [63:0] rsp_out_id_middle,
   output logic [31:0] rsp_out_id_low,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data
);

   import xdnt_pkg::*;

   localparam int unsigned AW = $clog2(TABLE_DEPTH);
   localparam int unsigned CW = AW + 1;
   localparam int unsigned NW = $clog2(PER_REQUEST + 1);
   localparam int unsigned EW = $bits(entry_type);

   fsm_type           state_ff, state_in;
   op_type            op_ff;
   logic [ID_W-1:0]   req_id_ff;
   logic [ADDR_W-1:0] req_addr_ff;
   logic [PORT_W-1:0] req_port_ff;
   logic              req_idp_ff;
   logic [ID_W-1:0]   target_ff;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [AW-1:0]     j_ff, j_in;
   logic [NW-1:0]     n_ff, n_in;
   entry_type         held_ff, held_in;
   logic              held_valid_ff, held_valid_in;
   entry_type         key_ff, key_in;
   result_type        rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   entry_type         ram_wdata, rd_entry, upd;
   logic [EW-1:0]     ram_rdata;
   logic              out_free, match, emit, req_accept;
   result_type        echo, emit_rec;

   xdnt_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_entry   = entry_type'(ram_rdata);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign match      = (rd_entry.address == req_addr_ff) && (rd_entry.port == req_port_ff);

   always_comb begin
      echo         = '0;
      echo.status  = ST_NOT_FOUND;
      echo.address = req_addr_ff;
      echo.port    = req_port_ff;
      echo.id      = req_id_ff;
      echo.last    = 1'b1;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      j_in          = j_ff;
      n_in          = n_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      key_in        = key_ff;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff[AW-1:0];
      ram_wdata     = rd_entry;
      ram_raddr     = idx_ff[AW-1:0];
      emit          = 1'b0;
      emit_rec      = echo;
      upd           = rd_entry;
      case (state_ff)
         S_IDLE: begin
            idx_in        = '0;
            n_in          = '0;
            held_valid_in = 1'b0;
            if (req_valid) begin
               case (op_type'(req_operation))
                  OP_NEXT: state_in = S_NX_RD;
                  OP_SORT: state_in = S_SO_NEXT;
                  default: state_in = S_FIND_RD;
               endcase
            end
         end
         S_FIND_RD: begin
            if (op_ff == OP_INSERT && req_port_ff == '0) begin
               if (out_free) begin
                  emit            = 1'b1;
                  emit_rec.status = ST_PORT_ZERO;
                  state_in        = S_IDLE;
               end
            end else if (idx_ff == count_ff) begin
               if (out_free) begin
                  emit     = 1'b1;
                  state_in = S_IDLE;
                  if (op_ff == OP_INSERT) begin
                     if (count_ff == CW'(TABLE_DEPTH)) begin
                        emit_rec.status = ST_FULL;
                     end else begin
                        emit_rec.status     = ST_ADDED;
                        ram_we              = 1'b1;
                        ram_waddr           = count_ff[AW-1:0];
                        ram_wdata.id        = req_id_ff;
                        ram_wdata.address   = req_addr_ff;
                        ram_wdata.port      = req_port_ff;
                        ram_wdata.queried   = 1'b0;
                        ram_wdata.responded = 1'b0;
                        count_in            = count_ff + CW'(1);
                     end
                  end
               end
            end else begin
               state_in = S_FIND_CK;
            end
         end
         S_FIND_CK: begin
            if (match) begin
               if (out_free) begin
                  emit     = 1'b1;
                  state_in = S_IDLE;
                  if (op_ff == OP_INSERT) begin
                     emit_rec.status = ST_DUPLICATE;
                  end else begin
                     upd.responded = 1'b1;
                     if (req_idp_ff) begin
                        upd.id = req_id_ff;
                     end
                     ram_we           = 1'b1;
                     ram_wdata        = upd;
                     emit_rec.status  = ST_FOUND;
                     emit_rec.address = upd.address;
                     emit_rec.port    = upd.port;
                     emit_rec.id      = upd.id;
                  end
               end
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_FIND_RD;
            end
         end
         S_NX_RD: begin
            if (idx_ff == count_ff || n_ff == NW'(PER_REQUEST)) begin
               if (out_free) begin
                  emit     = 1'b1;
                  state_in = S_IDLE;
                  emit_rec = '0;
                  emit_rec.last = 1'b1;
                  if (held_valid_ff) begin
                     emit_rec.status  = ST_GIVEN;
                     emit_rec.address = held_ff.address;
                     emit_rec.port    = held_ff.port;
                     emit_rec.id      = held_ff.id;
                  end else begin
                     emit_rec.status = ST_DONE;
                  end
               end
            end else begin
               state_in = S_NX_CK;
            end
         end
         S_NX_CK: begin
            if (rd_entry.queried) begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_NX_RD;
            end else if (!held_valid_ff || out_free) begin
               // the held node goes out once a later one proves it is not last
               if (held_valid_ff) begin
                  emit             = 1'b1;
                  emit_rec.status  = ST_GIVEN;
                  emit_rec.address = held_ff.address;
                  emit_rec.port    = held_ff.port;
                  emit_rec.id      = held_ff.id;
                  emit_rec.last    = 1'b0;
               end
               upd.queried   = 1'b1;
               ram_we        = 1'b1;
               ram_wdata     = upd;
               held_in       = upd;
               held_valid_in = 1'b1;
               n_in          = n_ff + NW'(1);
               idx_in        = idx_ff + CW'(1);
               state_in      = S_NX_RD;
            end
         end
         S_SO_NEXT: begin
            if ((idx_ff + CW'(1)) >= count_ff) begin
               state_in = S_SO_DONE;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_SO_KRD;
            end
         end
         S_SO_KRD: begin
            state_in = S_SO_KCK;
         end
         S_SO_KCK: begin
            key_in    = rd_entry;
            j_in      = idx_ff[AW-1:0];
            ram_raddr = idx_ff[AW-1:0] - AW'(1);
            state_in  = S_SO_CMP;
         end
         S_SO_CMP: begin
            // rd_entry holds entry j-1; shift it up while the key is closer
            ram_we    = 1'b1;
            ram_waddr = j_ff;
            if (nearer(key_ff.id, rd_entry.id, target_ff)) begin
               ram_wdata = rd_entry;
               j_in      = j_ff - AW'(1);
               ram_raddr = j_ff - AW'(2);
               if (j_ff == AW'(1)) begin
                  state_in = S_SO_PLACE;
               end
            end else begin
               ram_wdata = key_ff;
               state_in  = S_SO_NEXT;
            end
         end
         S_SO_PLACE: begin
            ram_we    = 1'b1;
            ram_waddr = j_ff;
            ram_wdata = key_ff;
            state_in  = S_SO_NEXT;
         end
         S_SO_DONE: begin
            if (out_free) begin
               emit            = 1'b1;
               emit_rec        = '0;
               emit_rec.status = ST_DONE;
               emit_rec.last   = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   assign rsp_in       = emit ? emit_rec : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         target_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_TARGET_HIGH:   target_ff[159:96] <= csr_write_data;
               CSR_TARGET_MIDDLE: target_ff[95:32]  <= csr_write_data;
               CSR_TARGET_LOW:    target_ff[31:0]   <= csr_write_data[31:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      j_ff    <= j_in;
      n_ff    <= n_in;
      held_ff <= held_in;
      key_ff  <= key_in;
      rsp_ff  <= rsp_in;
      if (req_accept) begin
         op_ff       <= op_type'(req_operation);
         req_id_ff   <= req_id_present ?
                        {req_in_id_high, req_in_id_middle, req_in_id_low} : '0;
         req_addr_ff <= req_in_address;
         req_port_ff <= req_in_port;
         req_idp_ff  <= req_id_present;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_out_address   = rsp_ff.address;
   assign rsp_out_port      = rsp_ff.port;
   assign rsp_out_id_high   = rsp_ff.id[159:96];
   assign rsp_out_id_middle = rsp_ff.id[95:32];
   assign rsp_out_id_low    = rsp_ff.id[31:0];
   assign rsp_last          = rsp_ff.last;

   `XDNT_ASSERT_HOLDS(a_count_bound, count_ff <= CW'(TABLE_DEPTH), "entry count past depth")
   `XDNT_ASSERT_HOLDS(a_emit_slot, !emit || out_free, "result overwrites pending response")
   `XDNT_ASSERT_NEXT(a_busy_after_req, req_accept, state_ff != S_IDLE, "request not started")
   `XDNT_ASSERT_HOLDS(a_held_counted, !held_valid_ff || n_ff != '0, "held node not counted")

endmodule

@@ rtl/core/xdnt_ram.sv @@
module xdnt_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ test/testbench.sv @@
module testbench;
   import xdnt_pkg::*;

   localparam int unsigned DEPTH = DEF_TABLE_DEPTH;
   localparam int unsigned HANDOUTS = DEF_PER_REQUEST;

   class node_table_scoreboard;
      logic [ID_W-1:0]   node_id[DEPTH];
      logic [ADDR_W-1:0] node_address[DEPTH];
      logic [PORT_W-1:0] node_port[DEPTH];
      logic              node_queried[DEPTH];
      logic              node_responded[DEPTH];
      int unsigned       node_count;
      logic [ID_W-1:0]   target;
      result_type        pending_results[$];
      int                error_count;

      function new();
         node_count = 0;
         target = '0;
         error_count = 0;
      endfunction

      task report(string what);
         $display("mismatch: %s", what);
         error_count++;
      endtask

      function void set_target(csr_index_type index, logic [63:0] value);
         case (index)
            CSR_TARGET_HIGH:   target[159:96] = value;
            CSR_TARGET_MIDDLE: target[95:32] = value;
            CSR_TARGET_LOW:    target[31:0] = value[31:0];
            default: ;
         endcase
      endfunction

      function int find_node(logic [ADDR_W-1:0] address, logic [PORT_W-1:0] port);
         for (int i = 0; i < node_count; i++)
            if (node_address[i] == address && node_port[i] == port) return i;
         return -1;
      endfunction

      function void push(status_type st, logic [ADDR_W-1:0] address,
                         logic [PORT_W-1:0] port, logic [ID_W-1:0] id, logic last);
         result_type r;
         r.status = st;
         r.address = address;
         r.port = port;
         r.id = id;
         r.last = last;
         pending_results.push_back(r);
      endfunction

      function void push_node(status_type st, int e, logic last);
         push(st, node_address[e], node_port[e], node_id[e], last);
      endfunction

      function void note_request(op_type op, logic [ID_W-1:0] id_in,
                                 logic [ADDR_W-1:0] address, logic [PORT_W-1:0] port,
                                 logic id_present);
         logic [ID_W-1:0] id;
         int              f;
         int              given;
         logic [ID_W-1:0] t_id;
         logic [ADDR_W-1:0] t_a;
         logic [PORT_W-1:0] t_p;
         logic            t_q, t_r;
         id = id_present ? id_in : '0;
         case (op)
            OP_INSERT: begin
               if (port == 0) push(ST_PORT_ZERO, address, port, id, 1'b1);
               else if (find_node(address, port) >= 0) push(ST_DUPLICATE, address, port, id, 1'b1);
               else if (node_count >= DEPTH) push(ST_FULL, address, port, id, 1'b1);
               else begin
                  node_id[node_count] = id;
                  node_address[node_count] = address;
                  node_port[node_count] = port;
                  node_queried[node_count] = 1'b0;
                  node_responded[node_count] = 1'b0;
                  node_count++;
                  push(ST_ADDED, address, port, id, 1'b1);
               end
            end
            OP_RESPOND: begin
               f = find_node(address, port);
               if (f < 0) push(ST_NOT_FOUND, address, port, id, 1'b1);
               else begin
                  node_responded[f] = 1'b1;
                  if (id_present) node_id[f] = id;
                  push_node(ST_FOUND, f, 1'b1);
               end
            end
            OP_NEXT: begin
               given = 0;
               for (int i = 0; i < node_count && given < HANDOUTS; i++) begin
                  if (!node_queried[i]) begin
                     node_queried[i] = 1'b1;
                     push_node(ST_GIVEN, i, 1'b0);
                     given++;
                  end
               end
               if (given == 0) push(ST_DONE, '0, '0, '0, 1'b1);
               else pending_results[$].last = 1'b1;
            end
            default: begin
               // stable insertion sort, strict compare keeps equal distances in order
               for (int i = 1; i < node_count; i++) begin
                  for (int j = i; j > 0 && ((node_id[j] ^ target) < (node_id[j-1] ^ target));
                       j--) begin
                     t_id = node_id[j]; node_id[j] = node_id[j-1]; node_id[j-1] = t_id;
                     t_a = node_address[j]; node_address[j] = node_address[j-1];
                     node_address[j-1] = t_a;
                     t_p = node_port[j]; node_port[j] = node_port[j-1]; node_port[j-1] = t_p;
                     t_q = node_queried[j]; node_queried[j] = node_queried[j-1];
                     node_queried[j-1] = t_q;
                     t_r = node_responded[j]; node_responded[j] = node_responded[j-1];
                     node_responded[j-1] = t_r;
                  end
               end
               push(ST_DONE, '0, '0, '0, 1'b1);
            end
         endcase
      endfunction

      task check_response(logic [2:0] st, logic [ADDR_W-1:0] address,
                          logic [PORT_W-1:0] port, logic [ID_W-1:0] id, logic last);
         result_type e;
         if (pending_results.size() == 0) begin
            report("response with nothing outstanding");
         end else begin
            e = pending_results.pop_front();
            if (st != e.status)
               report($sformatf("status got %0d want %0d", st, e.status));
            if (address != e.address)
               report($sformatf("address got %h want %h", address, e.address));
            if (port != e.port) report($sformatf("port got %h want %h", port, e.port));
            if (id != e.id) report($sformatf("id got %h want %h", id, e.id));
            if (last != e.last) report($sformatf("last got %b want %b", last, e.last));
         end
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_operation;
   logic [63:0] req_in_id_high;
   logic [63:0] req_in_id_middle;
   logic [31:0] req_in_id_low;
   logic [31:0] req_in_address;
   logic [15:0] req_in_port;
   logic        req_id_present;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_out_address;
   logic [15:0] rsp_out_port;
   logic [63:0] rsp_out_id_high;
   logic [63:0] rsp_out_id_middle;
   logic [31:0] rsp_out_id_low;
   logic        rsp_last;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [63:0] csr_write_data;

   node_table_scoreboard sb;
   bit   quiet;
   logic [31:0] known_address[$];
   logic [15:0] known_port[$];
   logic [ID_W-1:0] shared_id[4];

   xor_distance_node_table dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("Regression FAIL");
      $finish;
   end

   task send(op_type op, logic [ID_W-1:0] id, logic [31:0] address, logic [15:0] port,
             logic id_present);
      if (!quiet && $urandom_range(3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      {req_in_id_high, req_in_id_middle, req_in_id_low} <= id;
      req_in_address <= address;
      req_in_port <= port;
      req_id_present <= id_present;
      do @(posedge clock); while (!req_ready);
      sb.note_request(op, id, address, port, id_present);
      if (port != 0) begin
         known_address.push_back(address);
         known_port.push_back(port);
      end
   endtask

   task write_target(csr_index_type index, logic [63:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
      sb.set_target(index, value);
      csr_write_enable <= 1'b0;
   endtask

   task drain;
      req_valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function logic [ID_W-1:0] random_id();
      if ($urandom_range(2) == 0) return shared_id[$urandom_range(3)];
      return {$urandom, $urandom, $urandom, $urandom, $urandom};
   endfunction

   task random_request;
      int  k;
      logic [31:0] a;
      logic [15:0] p;
      op_type op;
      k = $urandom_range(99);
      op = k < 40 ? OP_INSERT : k < 65 ? OP_RESPOND : k < 87 ? OP_NEXT : OP_SORT;
      if (known_address.size() != 0 && $urandom_range(9) < 6) begin
         k = $urandom_range(known_address.size() - 1);
         a = known_address[k];
         p = known_port[k];
      end else begin
         a = $urandom;
         p = $urandom_range(7) == 0 ? 16'd0 : 16'($urandom);
      end
      send(op, random_id(), a, p, 1'($urandom));
   endtask

   // receiver; one long hold-off early on so the block backs up its input
   initial begin
      int seen;
      bit held_off;
      seen = 0;
      held_off = 1'b0;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         if (seen == 15 && !held_off) begin
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
         end
         if (!quiet && $urandom_range(3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         if (rsp_valid) begin
            seen++;
            sb.check_response(rsp_status, rsp_out_address, rsp_out_port,
                              {rsp_out_id_high, rsp_out_id_middle, rsp_out_id_low}, rsp_last);
         end
      end
   end

   initial begin
      logic [ID_W-1:0] ones;
      sb = new();
      quiet = 1'b0;
      ones = '1;
      for (int i = 0; i < 4; i++) shared_id[i] = {$urandom, $urandom, $urandom, $urandom, $urandom};
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_INSERT;
      req_in_id_high = '0;
      req_in_id_middle = '0;
      req_in_id_low = '0;
      req_in_address = '0;
      req_in_port = '0;
      req_id_present = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = CSR_TARGET_HIGH;
      csr_write_data = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      write_target(CSR_TARGET_HIGH, '1);
      write_target(CSR_TARGET_MIDDLE, '1);
      write_target(CSR_TARGET_LOW, '1);
      send(OP_NEXT, '0, '0, '0, 1'b0);               // empty table
      send(OP_SORT, '0, '0, '0, 1'b0);
      send(OP_RESPOND, ones, 32'h0a000001, 16'd80, 1'b1); // miss
      send(OP_INSERT, ones, 32'h01020304, 16'd0, 1'b1);   // port zero
      send(OP_INSERT, ones, '1, '1, 1'b1);
      send(OP_INSERT, ones, '0, 16'd1, 1'b0);             // id dropped
      send(OP_INSERT, '0, '1, '1, 1'b1);                  // duplicate
      send(OP_INSERT, shared_id[0], 32'h0a000001, 16'd80, 1'b1);
      send(OP_INSERT, shared_id[0], 32'h0a000002, 16'd80, 1'b1);
      send(OP_INSERT, '0, 32'h0a000003, 16'd81, 1'b1);
      send(OP_RESPOND, shared_id[1], '0, 16'd1, 1'b1);    // hit, new id
      send(OP_RESPOND, ones, 32'h0a000002, 16'd80, 1'b0); // hit, id kept
      send(OP_NEXT, '0, '0, '0, 1'b0);
      send(OP_NEXT, '0, '0, '0, 1'b1);
      send(OP_NEXT, '0, '0, '0, 1'b0);
      send(OP_SORT, '0, '0, '0, 1'b0);
      send(OP_INSERT, shared_id[0], 32'h0a000004, 16'd82, 1'b1);
      send(OP_SORT, '0, '0, '0, 1'b0);
      send(OP_NEXT, '0, '0, '0, 1'b0);
      drain();

      write_target(CSR_TARGET_HIGH, '0);
      write_target(CSR_TARGET_MIDDLE, '0);
      write_target(CSR_TARGET_LOW, '0);
      repeat (40) random_request();
      drain();
      write_target(CSR_TARGET_HIGH, {$urandom, $urandom});
      write_target(CSR_TARGET_MIDDLE, shared_id[2][95:32]);
      write_target(CSR_TARGET_LOW, $urandom);
      repeat (40) random_request();
      drain();

      // quiet tail: back to back requests with no idling
      quiet = 1'b1;
      write_target(CSR_TARGET_HIGH, shared_id[3][159:96]);
      send(OP_SORT, '0, '0, '0, 1'b0);
      repeat (4) random_request();
      send(OP_SORT, '0, '0, '0, 1'b0);
      send(OP_NEXT, '0, '0, '0, 1'b0);
      req_valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
